@@ src/median_filter_3x3_rgb_unit_defines.svh @@
// Assertion helpers for the port checker of the median filter.
`ifndef MEDIAN_FILTER_3X3_RGB_UNIT_DEFINES_SVH
`define MEDIAN_FILTER_3X3_RGB_UNIT_DEFINES_SVH

// Clocked check that is switched off while reset is asserted.
`define MF3_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define MF3_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/mf3_pkg.sv @@
package mf3_pkg;

	// Field and register widths.
	localparam int CHAN_W     = 8;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 11;
	localparam int ROW_W      = 11;

	// Frame size limits and reset values.
	localparam int MIN_DIM      = 3;
	localparam int MAX_HEIGHT   = 1024;
	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH  = 4'd0,
		CFG_IMAGE_HEIGHT = 4'd1
	} cfg_idx_t;

	// Input item commands.
	typedef enum logic {
		CMD_PIXEL = 1'b0,
		CMD_FLUSH = 1'b1
	} cmd_t;

	typedef logic [CHAN_W-1:0] chan_t;

	// Element 0 is the first channel, which sits in the low byte.
	typedef chan_t [2:0] pix_t;

	typedef struct packed {
		chan_t lo;
		chan_t mid;
		chan_t hi;
	} sort3_t;

	// One window column: each channel sorted over the three rows, plus the
	// unsorted middle row for pass-through of border pixels.
	typedef struct packed {
		pix_t lo;
		pix_t mid;
		pix_t hi;
		pix_t raw;
	} col_t;

	// Per-item control that travels with the pixel data down the pipeline.
	typedef struct packed {
		logic have;
		logic border;
		logic last;
	} meta_t;

	function automatic sort3_t sort3(chan_t a, chan_t b, chan_t c);
		chan_t x;
		chan_t y;
		chan_t z;
		chan_t t;
		sort3_t r;
		x = a;
		y = b;
		z = c;
		if (x > y) begin
			t = x;
			x = y;
			y = t;
		end
		if (y > z) begin
			t = y;
			y = z;
			z = t;
		end
		if (x > y) begin
			t = x;
			x = y;
			y = t;
		end
		r.lo  = x;
		r.mid = y;
		r.hi  = z;
		return r;
	endfunction

	function automatic chan_t max3(chan_t a, chan_t b, chan_t c);
		chan_t m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	function automatic chan_t min3(chan_t a, chan_t b, chan_t c);
		chan_t m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic chan_t med3(chan_t a, chan_t b, chan_t c);
		chan_t lo;
		chan_t hi;
		chan_t m;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		m  = (hi < c) ? hi : c;
		return (lo > m) ? lo : m;
	endfunction

endpackage

@@ src/mf3_line_ram.sv @@
// Line store: one write port and one read port with registered read data.
// A read and a write of the same address in one cycle return the old data.
module mf3_line_ram #(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  mf3_pkg::pix_t wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output mf3_pkg::pix_t rd_data_q
);

	mf3_pkg::pix_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

endmodule

@@ src/mf3_median_core.sv @@
// Window and median datapath. Each new column is sorted as it enters the
// window; the median of nine is then the median of the largest low, the
// middle of the mids and the smallest high over the three columns.
module mf3_median_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           v_s1,
	input  mf3_pkg::meta_t meta_s1,
	input  mf3_pkg::pix_t  up_s1,
	input  mf3_pkg::pix_t  lo_s1,
	input  mf3_pkg::pix_t  pix_s1,
	output logic           res_valid,
	output mf3_pkg::pix_t  res_pix,
	output logic           res_last
);

	mf3_pkg::sort3_t new_srt [3];
	mf3_pkg::col_t   col_new;
	mf3_pkg::col_t   win_s2 [3];
	mf3_pkg::meta_t  meta_s2;
	logic            v_s2;

	mf3_pkg::pix_t   lomax_d;
	mf3_pkg::pix_t   midmed_d;
	mf3_pkg::pix_t   himin_d;
	mf3_pkg::pix_t   lomax_s3;
	mf3_pkg::pix_t   midmed_s3;
	mf3_pkg::pix_t   himin_s3;
	mf3_pkg::pix_t   center_s3;
	mf3_pkg::meta_t  meta_s3;
	logic            v_s3;

	mf3_pkg::pix_t   res_d;
	mf3_pkg::pix_t   out_pix_q;
	logic            out_last_q;
	logic            out_valid_q;

	// Sort the incoming column per channel: top row, middle row, new pixel.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			new_srt[k]     = mf3_pkg::sort3(up_s1[k], lo_s1[k], pix_s1[k]);
			col_new.lo[k]  = new_srt[k].lo;
			col_new.mid[k] = new_srt[k].mid;
			col_new.hi[k]  = new_srt[k].hi;
		end
		col_new.raw = lo_s1;
	end

	// The window shifts only for items that update the frame state.
	always_ff @(posedge clk) begin
		if (en && v_s1) begin
			win_s2[0] <= win_s2[1];
			win_s2[1] <= win_s2[2];
			win_s2[2] <= col_new;
			meta_s2   <= meta_s1;
		end
	end

	// Reduce the three sorted columns to three candidates per channel.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lomax_d[k]  = mf3_pkg::max3(win_s2[0].lo[k], win_s2[1].lo[k], win_s2[2].lo[k]);
			midmed_d[k] = mf3_pkg::med3(win_s2[0].mid[k], win_s2[1].mid[k],
				win_s2[2].mid[k]);
			himin_d[k]  = mf3_pkg::min3(win_s2[0].hi[k], win_s2[1].hi[k], win_s2[2].hi[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s2) begin
			lomax_s3  <= lomax_d;
			midmed_s3 <= midmed_d;
			himin_s3  <= himin_d;
			center_s3 <= win_s2[1].raw;
			meta_s3   <= meta_s2;
		end
	end

	// Border pixels pass the window center; interior pixels take the median.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			res_d[k] = meta_s3.border ? center_s3[k]
				: mf3_pkg::med3(lomax_s3[k], midmed_s3[k], himin_s3[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s3 && meta_s3.have) begin
			out_pix_q  <= res_d;
			out_last_q <= meta_s3.last;
		end
	end

	// Stage valid bits; all stages move together when the output can advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3 && meta_s3.have;
		end
	end

	assign res_valid = out_valid_q;
	assign res_pix   = out_pix_q;
	assign res_last  = out_last_q;

endmodule

@@ src/median_filter_3x3_rgb_unit.sv @@
// Channel   Handshake            Payload
// --------  -------------------  --------------------------------------------
// input     in_valid / in_stall  command, chan0, chan1, chan2
// output    out_valid/out_stall  out_chan0, out_chan1, out_chan2, frame_last
// config    cfg_valid/cfg_ready  cfg_index, cfg_data (cfg_ready is always high)
//
// One item is accepted every cycle while no result is held back; the line
// store reads, the window and the two median stages form a four-register
// pipeline, through which an accepted item's result passes in that order.
// A stalled result freezes the whole pipeline and raises in_stall; a result
// that is taken in the same cycle lets the next item in at once.
// Reset clears the counters, the pipeline valid bits and the registers to 640
// by 480. The line stores get no clearing pass: every entry that reaches a
// result is written earlier in the same frame.
module median_filter_3x3_rgb_unit #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             command,
	input  logic [7:0]                       chan0,
	input  logic [7:0]                       chan1,
	input  logic [7:0]                       chan2,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       out_chan0,
	output logic [7:0]                       out_chan1,
	output logic [7:0]                       out_chan2,
	output logic                             frame_last,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mf3_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mf3_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int WEW  = $clog2(MAX_WIDTH + 1);
	localparam int CMPW = (WEW > mf3_pkg::CFG_DATA_W) ? WEW : mf3_pkg::CFG_DATA_W;
	localparam int RW   = mf3_pkg::ROW_W;

	localparam int WIDTH_RST_I = (mf3_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
		: mf3_pkg::RESET_WIDTH;
	localparam logic [WEW-1:0]  WIDTH_RST  = WEW'(WIDTH_RST_I);
	localparam logic [RW-1:0]   HEIGHT_RST = RW'(mf3_pkg::RESET_HEIGHT);
	localparam logic [CMPW-1:0] W_MIN      = CMPW'(mf3_pkg::MIN_DIM);
	localparam logic [CMPW-1:0] W_MAX      = CMPW'(MAX_WIDTH);
	localparam logic [RW-1:0]   H_MIN      = RW'(mf3_pkg::MIN_DIM);
	localparam logic [RW-1:0]   H_MAX      = RW'(mf3_pkg::MAX_HEIGHT);

	logic [WEW-1:0]  width_q;
	logic [RW-1:0]   height_q;
	logic [CMPW-1:0] cfg_ext;
	logic [CMPW-1:0] width_clamp;
	logic [RW-1:0]   height_clamp;
	logic            cfg_hit_w;
	logic            cfg_hit_h;

	logic [AW-1:0]   col_q;
	logic [RW-1:0]   row_q;

	logic            en;
	logic            accept;
	logic            upd;
	logic            wrap;
	logic            col_zero;
	mf3_pkg::pix_t   pix_in;
	mf3_pkg::meta_t  meta_in;

	logic            v_s1;
	mf3_pkg::meta_t  meta_s1;
	mf3_pkg::pix_t   pix_s1;
	logic [AW-1:0]   col_s1;
	mf3_pkg::pix_t   up_s1;
	mf3_pkg::pix_t   lo_s1;

	logic            res_valid;
	mf3_pkg::pix_t   res_pix;
	logic            res_last;

	// Register decode; writes to other indexes are dropped.
	always_comb begin
		cfg_hit_w = 1'b0;
		cfg_hit_h = 1'b0;
		case (cfg_index)
			mf3_pkg::CFG_IMAGE_WIDTH:  cfg_hit_w = cfg_valid;
			mf3_pkg::CFG_IMAGE_HEIGHT: cfg_hit_h = cfg_valid;
			default: begin
				cfg_hit_w = 1'b0;
				cfg_hit_h = 1'b0;
			end
		endcase
	end

	// Written sizes are clamped once, on the way into the registers.
	always_comb begin
		cfg_ext = CMPW'(cfg_data);
		if (cfg_ext < W_MIN) begin
			width_clamp = W_MIN;
		end else if (cfg_ext > W_MAX) begin
			width_clamp = W_MAX;
		end else begin
			width_clamp = cfg_ext;
		end
		if (cfg_data < H_MIN) begin
			height_clamp = H_MIN;
		end else if (cfg_data > H_MAX) begin
			height_clamp = H_MAX;
		end else begin
			height_clamp = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else begin
			if (cfg_hit_w) begin
				width_q <= width_clamp[WEW-1:0];
			end
			if (cfg_hit_h) begin
				height_q <= height_clamp;
			end
		end
	end

	assign cfg_ready = 1'b1;

	// Input handshake. An early flush is taken but leaves the state alone.
	assign en       = !res_valid || !out_stall;
	assign in_stall = !en;
	assign accept   = in_valid && en;
	assign upd      = accept && (command == mf3_pkg::CMD_PIXEL || row_q >= height_q);

	// Flush items feed zeros into the stores; a surplus pixel keeps its data.
	always_comb begin
		if (command == mf3_pkg::CMD_PIXEL) begin
			pix_in[0] = chan0;
			pix_in[1] = chan1;
			pix_in[2] = chan2;
		end else begin
			pix_in = '0;
		end
	end

	// Position of the released result relative to the frame edges.
	assign col_zero       = (col_q == '0);
	assign wrap           = (WEW'(col_q) + WEW'(1)) >= width_q;
	assign meta_in.have   = (row_q >= RW'(2)) || (row_q == RW'(1) && !col_zero);
	assign meta_in.border = col_zero || (col_q == AW'(1)) || (row_q == RW'(1))
		|| (row_q == height_q);
	assign meta_in.last   = col_zero && (row_q == height_q + RW'(1));

	// Raster position of the next item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_hit_w || cfg_hit_h) begin
			col_q <= '0;
			row_q <= '0;
		end else if (upd) begin
			if (meta_in.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// First pipeline stage: item data alongside the line store reads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= upd;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			pix_s1  <= pix_in;
			col_s1  <= col_q;
			meta_s1 <= meta_in;
		end
	end

	// The lower store takes the new pixel; the upper store takes what the
	// lower store held, from the lower store's read register.
	mf3_line_ram #(
		.DEPTH(MAX_WIDTH)
	) u_lower (
		.clk       (clk),
		.we        (upd),
		.waddr     (col_q),
		.wdata     (pix_in),
		.re        (upd),
		.raddr     (col_q),
		.rd_data_q (lo_s1)
	);

	mf3_line_ram #(
		.DEPTH(MAX_WIDTH)
	) u_upper (
		.clk       (clk),
		.we        (en && v_s1),
		.waddr     (col_s1),
		.wdata     (lo_s1),
		.re        (upd),
		.raddr     (col_q),
		.rd_data_q (up_s1)
	);

	mf3_median_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.v_s1      (v_s1),
		.meta_s1   (meta_s1),
		.up_s1     (up_s1),
		.lo_s1     (lo_s1),
		.pix_s1    (pix_s1),
		.res_valid (res_valid),
		.res_pix   (res_pix),
		.res_last  (res_last)
	);

	assign out_valid  = res_valid;
	assign out_chan0  = res_pix[0];
	assign out_chan1  = res_pix[1];
	assign out_chan2  = res_pix[2];
	assign frame_last = res_last;

endmodule

@@ src/mf3_checker.sv @@
`include "median_filter_3x3_rgb_unit_defines.svh"

// Port-level checks on the median filter.
module mf3_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_chan0,
	input logic [7:0] out_chan1,
	input logic [7:0] out_chan2,
	input logic       frame_last
);

	// A held result keeps its value until it is taken.
	`MF3_ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_chan0) && $stable(out_chan1) && $stable(out_chan2) && $stable(frame_last), "stalled result changed")

	// The input only waits behind a result that is itself held back.
	`MF3_ASSERT_CLK(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without a held result")

	// Reset leaves no result on offer and no item refused.
	`MF3_ASSERT_RST(a_reset_quiet, !arst_n |=> !out_valid && !in_stall, "activity after reset")

endmodule

bind median_filter_3x3_rgb_unit mf3_checker u_mf3_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.out_chan0  (out_chan0),
	.out_chan1  (out_chan1),
	.out_chan2  (out_chan2),
	.frame_last (frame_last)
);

@@ bench/median_filter_3x3_rgb_unit_tb.sv @@
`timescale 1ns / 100ps

module median_filter_3x3_rgb_unit_tb;

	localparam int MAX_W        = 1024;
	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 6;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 1000000;

	typedef logic [mf3_pkg::CFG_IDX_W-1:0]  cfg_index_t;
	typedef logic [mf3_pkg::CFG_DATA_W-1:0] cfg_word_t;

	// Indexes past the end of the register list; writes to them are dropped.
	localparam cfg_index_t CFG_SPARE_FIRST = 4'd2;
	localparam cfg_index_t CFG_SPARE_LAST  = 4'd15;

	typedef struct packed {
		mf3_pkg::pix_t px;
		logic          last;
	} filtered_t;

	logic                  clk;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_stall;
	logic                  command    = mf3_pkg::CMD_PIXEL;
	logic [7:0]            chan0      = '0;
	logic [7:0]            chan1      = '0;
	logic [7:0]            chan2      = '0;
	logic                  out_valid;
	logic                  out_stall  = 1'b0;
	logic [7:0]            out_chan0;
	logic [7:0]            out_chan1;
	logic [7:0]            out_chan2;
	logic                  frame_last;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	cfg_index_t            cfg_index  = '0;
	cfg_word_t             cfg_data   = '0;

	// Filter state mirrored by the testbench.
	mf3_pkg::pix_t         upper_line [MAX_W];
	mf3_pkg::pix_t         lower_line [MAX_W];
	mf3_pkg::pix_t         win [9];
	int                    col_pos;
	int                    row_pos;
	cfg_word_t             width_reg;
	cfg_word_t             height_reg;

	filtered_t             pending_pixels [$];
	int                    idle_pct;
	int                    stall_pct;
	int                    mismatch_count;
	int                    cycle_count;

	median_filter_3x3_rgb_unit #(
		.MAX_WIDTH(MAX_W)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.chan0     (chan0),
		.chan1     (chan1),
		.chan2     (chan2),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_chan0 (out_chan0),
		.out_chan1 (out_chan1),
		.out_chan2 (out_chan2),
		.frame_last(frame_last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Frame sizes outside the legal range are used clamped.
	function automatic int eff_dim(cfg_word_t v, int top);
		if (int'(v) < mf3_pkg::MIN_DIM)
			return mf3_pkg::MIN_DIM;
		if (int'(v) > top)
			return top;
		return int'(v);
	endfunction

	// Median of one channel over the nine window pixels.
	function automatic mf3_pkg::chan_t window_median(int ch);
		mf3_pkg::chan_t s [9];
		mf3_pkg::chan_t t;
		int j;
		for (int i = 0; i < 9; i++)
			s[i] = win[i][ch];
		for (int i = 1; i < 9; i++) begin
			t = s[i];
			j = i - 1;
			while (j >= 0 && s[j] > t) begin
				s[j + 1] = s[j];
				j--;
			end
			s[j + 1] = t;
		end
		return s[4];
	endfunction

	// Advances the mirrored filter by one accepted item and queues the
	// pixel it releases, if any.
	task automatic track_item(mf3_pkg::cmd_t cmd, mf3_pkg::pix_t px_in);
		int w;
		int h;
		int c;
		int orow;
		int ocol;
		mf3_pkg::pix_t px;
		mf3_pkg::pix_t up;
		mf3_pkg::pix_t lo;
		logic have;
		filtered_t res;
		w = eff_dim(width_reg, MAX_W);
		h = eff_dim(height_reg, mf3_pkg::MAX_HEIGHT);
		// A flush before the frame is complete is dropped.
		if (row_pos < h && cmd == mf3_pkg::CMD_FLUSH)
			return;
		px = (cmd == mf3_pkg::CMD_PIXEL) ? px_in : '0;
		c = (col_pos >= w) ? 0 : col_pos;
		up = upper_line[c];
		lo = lower_line[c];
		upper_line[c] = lo;
		lower_line[c] = px;
		for (int k = 0; k < 3; k++) begin
			win[k * 3]     = win[k * 3 + 1];
			win[k * 3 + 1] = win[k * 3 + 2];
		end
		win[2] = up;
		win[5] = lo;
		win[8] = px;
		have = (row_pos >= 2) || (row_pos == 1 && c >= 1);
		if (c == 0) begin
			orow = row_pos - 2;
			ocol = w - 1;
		end else begin
			orow = row_pos - 1;
			ocol = c - 1;
		end
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos++;
		end else begin
			col_pos = c + 1;
		end
		if (!have)
			return;
		// Border pixels pass through; interior pixels take the median.
		for (int ch = 0; ch < 3; ch++) begin
			if (orow == 0 || orow == h - 1 || ocol == 0 || ocol == w - 1)
				res.px[ch] = win[4][ch];
			else
				res.px[ch] = window_median(ch);
		end
		res.last = (orow == h - 1 && ocol == w - 1);
		if (res.last) begin
			col_pos = 0;
			row_pos = 0;
		end
		pending_pixels.push_back(res);
	endtask

	function automatic mf3_pkg::chan_t rand_chan();
		if ($urandom_range(3) == 0)
			return mf3_pkg::chan_t'($urandom_range(3) * 85);
		return mf3_pkg::chan_t'($urandom_range(255));
	endfunction

	function automatic mf3_pkg::pix_t rand_pix();
		mf3_pkg::pix_t p;
		for (int ch = 0; ch < 3; ch++)
			p[ch] = rand_chan();
		return p;
	endfunction

	// Offers one item, after idle cycles drawn one at a time, and waits for
	// it to be taken.
	task automatic send_item(mf3_pkg::cmd_t cmd, mf3_pkg::pix_t px);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		chan0    <= px[0];
		chan1    <= px[1];
		chan2    <= px[2];
		do
			@(posedge clk);
		while (in_stall);
		track_item(cmd, px);
	endtask

	// Stops the input and lets the pipeline empty.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, cfg_word_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == mf3_pkg::CFG_IMAGE_WIDTH) begin
			width_reg = val;
			col_pos = 0;
			row_pos = 0;
		end else if (idx == mf3_pkg::CFG_IMAGE_HEIGHT) begin
			height_reg = val;
			col_pos = 0;
			row_pos = 0;
		end
		@(posedge clk);
	endtask

	// Sends the pixels of one frame, stopping early at cut when cut is not
	// negative; a complete frame is followed by its tail of flush items,
	// some of them replaced by surplus pixels.
	task automatic send_frame(int w, int h, int noise_pct, int cut);
		int n;
		n = (cut >= 0 && cut < w * h) ? cut : w * h;
		for (int i = 0; i < n; i++) begin
			if (noise_pct != 0 && $urandom_range(99) < noise_pct)
				send_item(mf3_pkg::CMD_FLUSH, rand_pix());
			send_item(mf3_pkg::CMD_PIXEL, rand_pix());
		end
		if (n == w * h) begin
			for (int i = 0; i <= w; i++)
				send_item(mf3_pkg::cmd_t'(($urandom_range(3) == 0) ? mf3_pkg::CMD_PIXEL
					: mf3_pkg::CMD_FLUSH), rand_pix());
		end
	endtask

	// One 3x3 frame with extreme channel values, an early flush before and
	// during the frame, and a surplus pixel in the tail.
	task automatic test_directed_small_frame();
		mf3_pkg::chan_t vals [9];
		mf3_pkg::pix_t px;
		vals = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd127, 8'hAA, 8'h55, 8'd7};
		idle_pct = 0;
		stall_pct = 0;
		write_reg(mf3_pkg::CFG_IMAGE_WIDTH, 11'd3);
		write_reg(mf3_pkg::CFG_IMAGE_HEIGHT, 11'd3);
		send_item(mf3_pkg::CMD_FLUSH, '1);
		for (int i = 0; i < 9; i++) begin
			px[0] = vals[i];
			px[1] = vals[8 - i];
			px[2] = ~vals[i];
			send_item(mf3_pkg::CMD_PIXEL, px);
			if (i == 4)
				send_item(mf3_pkg::CMD_FLUSH, '0);
		end
		send_item(mf3_pkg::CMD_PIXEL, '1);
		repeat (3) send_item(mf3_pkg::CMD_FLUSH, '0);
		settle();
	endtask

	// Writes in the middle of a frame: a spare index leaves the frame going,
	// a real register abandons it.
	task automatic test_midframe_write();
		idle_pct = 0;
		stall_pct = 25;
		write_reg(mf3_pkg::CFG_IMAGE_WIDTH, 11'd5);
		write_reg(mf3_pkg::CFG_IMAGE_HEIGHT, 11'd4);
		for (int i = 0; i < 8; i++)
			send_item(mf3_pkg::CMD_PIXEL, rand_pix());
		settle();
		write_reg(CFG_SPARE_FIRST, 11'h7FF);
		write_reg(CFG_SPARE_LAST, 11'h000);
		for (int i = 8; i < 20; i++)
			send_item(mf3_pkg::CMD_PIXEL, rand_pix());
		repeat (6) send_item(mf3_pkg::CMD_FLUSH, rand_pix());
		send_frame(5, 4, 0, 9);
		settle();
		write_reg(mf3_pkg::CFG_IMAGE_WIDTH, 11'd5);
		send_frame(5, 4, 0, -1);
		settle();
	endtask

	// Register values below and above the legal range, and the start of a
	// frame at the largest width.
	task automatic test_extreme_sizes();
		idle_pct = 0;
		stall_pct = 0;
		write_reg(mf3_pkg::CFG_IMAGE_WIDTH, 11'd0);
		write_reg(mf3_pkg::CFG_IMAGE_HEIGHT, 11'd0);
		send_frame(mf3_pkg::MIN_DIM, mf3_pkg::MIN_DIM, 0, -1);
		settle();
		write_reg(mf3_pkg::CFG_IMAGE_WIDTH, 11'h7FF);
		write_reg(mf3_pkg::CFG_IMAGE_HEIGHT, 11'h7FF);
		send_frame(MAX_W, mf3_pkg::MAX_HEIGHT, 0, MAX_W + 6);
		settle();
	endtask

	function automatic cfg_word_t pick_dim(int typ_hi, int rare_hi);
		int r;
		r = $urandom_range(19);
		if (r == 0)
			return cfg_word_t'($urandom_range(0, mf3_pkg::MIN_DIM - 1));
		if (r == 1)
			return cfg_word_t'($urandom_range(typ_hi + 1, rare_hi));
		return cfg_word_t'($urandom_range(mf3_pkg::MIN_DIM, typ_hi));
	endfunction

	// Random frames, mostly complete, some cut short, with a new size now
	// and then and early flushes mixed in.
	task automatic test_random_traffic(int idle, int stall, int pixel_budget);
		int sent;
		int cut;
		int w;
		int h;
		logic need_cfg;
		idle_pct = idle;
		stall_pct = stall;
		sent = 0;
		need_cfg = 1'b1;
		while (sent < pixel_budget) begin
			if (need_cfg || $urandom_range(1) == 0) begin
				settle();
				if ($urandom_range(7) == 0)
					write_reg(cfg_index_t'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
						cfg_word_t'($urandom_range(2047)));
				if ($urandom_range(1) == 0) begin
					write_reg(mf3_pkg::CFG_IMAGE_WIDTH, pick_dim(12, 40));
					write_reg(mf3_pkg::CFG_IMAGE_HEIGHT, pick_dim(8, 16));
				end else begin
					write_reg(mf3_pkg::CFG_IMAGE_HEIGHT, pick_dim(8, 16));
					write_reg(mf3_pkg::CFG_IMAGE_WIDTH, pick_dim(12, 40));
				end
			end
			w = eff_dim(width_reg, MAX_W);
			h = eff_dim(height_reg, mf3_pkg::MAX_HEIGHT);
			cut = ($urandom_range(9) == 0) ? $urandom_range(0, w * h - 1) : -1;
			send_frame(w, h, 5, cut);
			sent += (cut >= 0) ? cut : w * h;
			need_cfg = (cut >= 0);
		end
		settle();
	endtask

	// Receiver back-pressure.
	always @(posedge clk)
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

	// Compare each delivered pixel with the oldest pending one.
	always @(posedge clk) begin : check_results
		filtered_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected result %0d %0d %0d last %0b", $time,
					out_chan0, out_chan1, out_chan2, frame_last);
				mismatch_count++;
			end else begin
				want = pending_pixels.pop_front();
				if (out_chan0 !== want.px[0]) begin
					$display("%0t: out_chan0 expected %0d, got %0d", $time,
						want.px[0], out_chan0);
					mismatch_count++;
				end
				if (out_chan1 !== want.px[1]) begin
					$display("%0t: out_chan1 expected %0d, got %0d", $time,
						want.px[1], out_chan1);
					mismatch_count++;
				end
				if (out_chan2 !== want.px[2]) begin
					$display("%0t: out_chan2 expected %0d, got %0d", $time,
						want.px[2], out_chan2);
					mismatch_count++;
				end
				if (frame_last !== want.last) begin
					$display("%0t: frame_last expected %0b, got %0b", $time,
						want.last, frame_last);
					mismatch_count++;
				end
			end
		end
	end

	// Run-away guard.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		mismatch_count = 0;
		cycle_count = 0;
		idle_pct = 0;
		stall_pct = 0;
		for (int i = 0; i < MAX_W; i++) begin
			upper_line[i] = '0;
			lower_line[i] = '0;
		end
		for (int i = 0; i < 9; i++)
			win[i] = '0;
		col_pos = 0;
		row_pos = 0;
		width_reg = cfg_word_t'(mf3_pkg::RESET_WIDTH);
		height_reg = cfg_word_t'(mf3_pkg::RESET_HEIGHT);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_small_frame();
		test_midframe_write();
		test_extreme_sizes();
		test_random_traffic(0, 0, 160);
		test_random_traffic(52, 0, 160);
		test_random_traffic(0, 52, 160);
		test_random_traffic(27, 27, 160);

		if (mismatch_count == 0 && pending_pixels.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+src
src/mf3_pkg.sv
src/mf3_line_ram.sv
src/mf3_median_core.sv
src/median_filter_3x3_rgb_unit.sv
src/mf3_checker.sv
bench/median_filter_3x3_rgb_unit_tb.sv
